### hdl/cebj_pkg.sv
// Shared types and constants for the capped exponential backoff jitter unit.
package cebj_pkg;

    // Field and port widths.
    localparam int CFG_W   = 16;
    localparam int RETRY_W = 8;
    localparam int RND_W   = 32;
    localparam int DELAY_W = 17;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Configuration register defaults after reset.
    localparam logic [CFG_W-1:0] RST_MIN_BACKOFF = 16'd10;
    localparam logic [CFG_W-1:0] RST_CAPPED_BASE = 16'd640;
    localparam logic [CFG_W-1:0] RST_MAX_BACKOFF = 16'd1000;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_MIN_BACKOFF = 2'd0,
        REG_CAPPED_BASE = 2'd1,
        REG_MAX_BACKOFF = 2'd2
    } reg_idx_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [CFG_W-1:0] min_backoff;
        logic [CFG_W-1:0] capped_base;
        logic [CFG_W-1:0] max_backoff;
    } cfg_t;

    // One item between the base/window front end and the remainder pipeline.
    typedef struct packed {
        logic [CFG_W-1:0] base;
        logic [CFG_W-1:0] divisor;
        logic [RND_W-1:0] rnd;
    } job_t;

endpackage

### hdl/capped_exponential_backoff_jitter_unit.sv
// Pipeline from item acceptance to delay_out valid: two stages for the capped
// base and jitter window, 32 remainder stages (one random_word bit each)
// and one output stage that adds base and remainder.
// Throughput: one item per cycle; a stall at the output backs up stage by stage.
// Reset clears all pipeline valid bits and loads min 10, capped base 640, max 1000.
module capped_exponential_backoff_jitter_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cebj_pkg::ADDR_W-1:0]  paddr,
    input  logic [cebj_pkg::DATA_W-1:0]  pwdata,
    output logic [cebj_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cebj_pkg::RETRY_W-1:0] retry_number,
    input  logic [cebj_pkg::RND_W-1:0]   random_word,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cebj_pkg::DELAY_W-1:0] delay_out
);
    import cebj_pkg::*;

    cfg_t cfg;
    job_t job;
    logic job_valid;
    logic job_ready;

    // Configuration registers.
    cebj_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Base delay and jitter window.
    cebj_base_calc u_base_calc (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .retry_number (retry_number),
        .random_word  (random_word),
        .out_valid    (job_valid),
        .out_ready    (job_ready),
        .job          (job)
    );

    // Jitter remainder and final delay.
    cebj_mod_pipe u_mod_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (job_valid),
        .in_ready  (job_ready),
        .job       (job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .delay_out (delay_out)
    );

endmodule

### hdl/cebj_cfg_regs.sv
// APB-style configuration registers for min, capped base and max backoff.
module cebj_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cebj_pkg::ADDR_W-1:0] paddr,
    input  logic [cebj_pkg::DATA_W-1:0] pwdata,
    output logic [cebj_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output cebj_pkg::cfg_t             cfg
);
    import cebj_pkg::*;

    logic [CFG_W-1:0] min_backoff_reg;
    logic [CFG_W-1:0] capped_base_reg;
    logic [CFG_W-1:0] max_backoff_reg;
    logic [CFG_W-1:0] min_backoff_next;
    logic [CFG_W-1:0] capped_base_next;
    logic [CFG_W-1:0] max_backoff_next;
    logic             wr_en;
    reg_idx_t         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    // Write decode; an address beyond the last register is ignored.
    always_comb
    begin
        min_backoff_next = min_backoff_reg;
        capped_base_next = capped_base_reg;
        max_backoff_next = max_backoff_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIN_BACKOFF: min_backoff_next = pwdata[CFG_W-1:0];
                REG_CAPPED_BASE: capped_base_next = pwdata[CFG_W-1:0];
                REG_MAX_BACKOFF: max_backoff_next = pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_backoff_reg <= RST_MIN_BACKOFF;
            capped_base_reg <= RST_CAPPED_BASE;
            max_backoff_reg <= RST_MAX_BACKOFF;
        end
        else
        begin
            min_backoff_reg <= min_backoff_next;
            capped_base_reg <= capped_base_next;
            max_backoff_reg <= max_backoff_next;
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_BACKOFF: prdata = {{(DATA_W-CFG_W){1'b0}}, min_backoff_reg};
            REG_CAPPED_BASE: prdata = {{(DATA_W-CFG_W){1'b0}}, capped_base_reg};
            REG_MAX_BACKOFF: prdata = {{(DATA_W-CFG_W){1'b0}}, max_backoff_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.min_backoff = min_backoff_reg;
    assign cfg.capped_base = capped_base_reg;
    assign cfg.max_backoff = max_backoff_reg;

endmodule

### hdl/cebj_base_calc.sv
// Two-stage front end: capped base delay, then jitter window and divisor.
module cebj_base_calc (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cebj_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cebj_pkg::RETRY_W-1:0] retry_number,
    input  logic [cebj_pkg::RND_W-1:0]   random_word,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cebj_pkg::job_t               job
);
    import cebj_pkg::*;

    logic               a_valid_reg;
    logic [CFG_W-1:0]   a_base_reg;
    logic [RND_W-1:0]   a_rnd_reg;
    logic               b_valid_reg;
    job_t               b_job_reg;
    logic               a_ready;
    logic               b_ready;

    logic [CFG_W-1:0]   half;
    logic [RETRY_W-1:0] shift_cnt;
    logic [4:0]         shift_amt;
    logic [2*CFG_W-1:0] scaled;
    logic               reach;
    logic [CFG_W-1:0]   base_a;

    logic [CFG_W-1:0]   diff;
    logic [CFG_W-1:0]   window;
    logic [CFG_W-1:0]   divisor_b;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Stage A: the doubling loop in closed form. The base is checked against
    // half the cap before each doubling and only grows, so only the check
    // before the last doubling decides whether the cap is reached.
    always_comb
    begin
        half      = cfg.capped_base >> 1;
        shift_cnt = retry_number - 8'd1;
        shift_amt = (shift_cnt > 8'd16) ? 5'd16 : shift_cnt[4:0];
        scaled    = {{CFG_W{1'b0}}, cfg.min_backoff} << shift_amt;
        reach     = scaled >= {{CFG_W{1'b0}}, half};
        if (retry_number == '0)
        begin
            base_a = (cfg.min_backoff > cfg.capped_base) ? cfg.capped_base
                                                          : cfg.min_backoff;
        end
        else if (reach)
        begin
            base_a = cfg.capped_base;
        end
        else
        begin
            // Below half the cap, so one more doubling stays within 16 bits.
            base_a = {scaled[CFG_W-2:0], 1'b0};
        end
    end

    // Stage B: jitter window limited to base-1; a zero base gives a zero window.
    always_comb
    begin
        diff = cfg.max_backoff - a_base_reg;
        if (a_base_reg == '0)
        begin
            window = '0;
        end
        else if ((cfg.max_backoff >= a_base_reg) && (diff < a_base_reg))
        begin
            window = diff;
        end
        else
        begin
            window = a_base_reg - 16'd1;
        end
        divisor_b = window + 16'd1;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_base_reg <= base_a;
            a_rnd_reg  <= random_word;
        end
        if (b_ready && a_valid_reg)
        begin
            b_job_reg.base    <= a_base_reg;
            b_job_reg.divisor <= divisor_b;
            b_job_reg.rnd     <= a_rnd_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign job       = b_job_reg;

    // The divisor never exceeds a nonzero base.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && (b_job_reg.base != '0) |-> b_job_reg.divisor <= b_job_reg.base)
        else $error("divisor exceeds base");

    // A zero base must give a unit divisor so the delay comes out as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && (b_job_reg.base == '0) |-> b_job_reg.divisor == 16'd1)
        else $error("zero base without unit divisor");

    // An item in stage A moves to stage B when stage B can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && b_ready |=> b_valid_reg)
        else $error("item lost between stage A and stage B");

endmodule

### hdl/cebj_mod_pipe.sv
// Pipelined restoring remainder, one dividend bit per stage, then base plus jitter.
module cebj_mod_pipe (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cebj_pkg::job_t               job,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cebj_pkg::DELAY_W-1:0] delay_out
);
    import cebj_pkg::*;

    localparam int N = RND_W;

    logic               v_reg    [N];
    logic [CFG_W-1:0]   rem_reg  [N];
    logic [RND_W-1:0]   num_reg  [N];
    logic [CFG_W-1:0]   div_reg  [N];
    logic [CFG_W-1:0]   base_reg [N];
    logic               out_valid_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [N:0]         rdy;

    // Each stage can load when it is empty or its contents move on.
    assign rdy[N]   = !out_valid_reg || out_ready;
    assign in_ready = rdy[0];

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_stage
            logic             src_v;
            logic [CFG_W-1:0] src_rem;
            logic [RND_W-1:0] src_num;
            logic [CFG_W-1:0] src_div;
            logic [CFG_W-1:0] src_base;
            logic [CFG_W:0]   trial;
            logic             ge;
            logic [CFG_W-1:0] rem_step;

            assign rdy[gi] = !v_reg[gi] || rdy[gi+1];

            // Stage inputs: the new item at the head, the previous stage elsewhere.
            if (gi == 0)
            begin : g_head
                assign src_v    = in_valid;
                assign src_rem  = '0;
                assign src_num  = job.rnd;
                assign src_div  = job.divisor;
                assign src_base = job.base;
            end
            else
            begin : g_body
                assign src_v    = v_reg[gi-1];
                assign src_rem  = rem_reg[gi-1];
                assign src_num  = num_reg[gi-1];
                assign src_div  = div_reg[gi-1];
                assign src_base = base_reg[gi-1];
            end

            // One restoring step: bring in the next dividend bit, subtract if it fits.
            always_comb
            begin
                trial    = {src_rem, src_num[RND_W-1]};
                ge       = trial >= {1'b0, src_div};
                rem_step = ge ? CFG_W'(trial - {1'b0, src_div}) : trial[CFG_W-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[gi] <= 1'b0;
                end
                else if (rdy[gi])
                begin
                    v_reg[gi] <= src_v;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[gi] && src_v)
                begin
                    rem_reg[gi]  <= rem_step;
                    num_reg[gi]  <= {src_num[RND_W-2:0], 1'b0};
                    div_reg[gi]  <= src_div;
                    base_reg[gi] <= src_base;
                end
            end
        end
    endgenerate

    // Output register: base plus the final remainder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rdy[N])
        begin
            out_valid_reg <= v_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[N] && v_reg[N-1])
        begin
            delay_reg <= DELAY_W'(base_reg[N-1]) + DELAY_W'(rem_reg[N-1]);
        end
    end

    assign out_valid = out_valid_reg;
    assign delay_out = delay_reg;

    // The window logic upstream never hands over a zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] |-> div_reg[0] != '0)
        else $error("zero divisor entered remainder pipeline");

    // After the last step the remainder is below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[N-1] |-> rem_reg[N-1] < div_reg[N-1])
        else $error("final remainder not reduced");

    // A finished remainder reaches the output register when that register can load.
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[N-1] && rdy[N] |=> out_valid_reg)
        else $error("item lost at output register");

endmodule
